// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// ante in a cycle implies cons in that same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/aomd_pkg.sv =====
// Types, constants and tables for the orientation and motion detector
package aomd_pkg;

   localparam int CordicSteps = 16;
   localparam int StepIdxW    = 5;
   localparam int CxW         = 36;
   localparam int AngW        = 28;
   localparam int DegQ        = 16;

   localparam logic signed [15:0] OneG = 16'sd16384;

   localparam logic [16:0] ShakeLimitRst = 17'd8192;
   localparam logic [14:0] FlipLimitRst  = 15'd8192;
   localparam logic [14:0] HorizLimitRst = 15'd11468;
   localparam logic [14:0] VertLimitRst  = 15'd4916;

   typedef enum logic [2:0] {
      CSR_X_MISSING   = 3'd0,
      CSR_Y_MISSING   = 3'd1,
      CSR_Z_MISSING   = 3'd2,
      CSR_SHAKE_LIMIT = 3'd3,
      CSR_FLIP_LIMIT  = 3'd4,
      CSR_HORIZ_LIMIT = 3'd5,
      CSR_VERT_LIMIT  = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_RUN  = 2'd1,
      S_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic signed [CxW-1:0]  x;
      logic signed [CxW-1:0]  y;
      logic signed [AngW-1:0] ang;
   } lane_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [AngW-1:0] atan_q16(input logic [StepIdxW-1:0] i);
      logic signed [AngW-1:0] r;
      unique case (i)
         5'd0:  r = 28'sd2949120;
         5'd1:  r = 28'sd1740967;
         5'd2:  r = 28'sd919879;
         5'd3:  r = 28'sd466945;
         5'd4:  r = 28'sd234379;
         5'd5:  r = 28'sd117304;
         5'd6:  r = 28'sd58666;
         5'd7:  r = 28'sd29335;
         5'd8:  r = 28'sd14668;
         5'd9:  r = 28'sd7334;
         5'd10: r = 28'sd3667;
         5'd11: r = 28'sd1833;
         5'd12: r = 28'sd917;
         5'd13: r = 28'sd458;
         5'd14: r = 28'sd229;
         5'd15: r = 28'sd115;
         5'd16: r = 28'sd57;
         5'd17: r = 28'sd29;
         5'd18: r = 28'sd14;
         5'd19: r = 28'sd7;
         5'd20: r = 28'sd4;
         5'd21: r = 28'sd2;
         5'd22: r = 28'sd1;
         default: r = 28'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/aomd_if.sv =====
// Channel interfaces: sample input, result output, register write
interface aomd_req_if;
   logic               valid;
   logic               ready;
   logic               from_analog;
   logic signed [15:0] sample_x;
   logic signed [15:0] sample_y;
   logic signed [15:0] sample_z;
   modport source (output valid, from_analog, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, from_analog, sample_x, sample_y, sample_z, output ready);
endinterface

interface aomd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [8:0]         heading_deg;
   logic               is_level;
   logic               is_upright;
   logic               shaking;
   logic               flipped;
   modport source (output valid, norm_x, norm_y, norm_z, heading_deg, is_level,
                   is_upright, shaking, flipped, input ready);
   modport sink   (input valid, norm_x, norm_y, norm_z, heading_deg, is_level,
                   is_upright, shaking, flipped, output ready);
endinterface

interface aomd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/aomd_cordic_cell.sv =====
// One CORDIC vectoring iteration, registered; cells chain into the angle pipe
module aomd_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [aomd_pkg::StepIdxW-1:0]    step_idx,
   input  logic                             vld_in,
   input  aomd_pkg::lane_type               lane_in,
   output logic                             vld_out,
   output aomd_pkg::lane_type               lane_out
);
   logic               vld_ff;
   aomd_pkg::lane_type lane_ff, lane_in_nxt;
   logic signed [aomd_pkg::CxW-1:0] dx, dy;

   always_comb begin
      dx = lane_in.y >>> step_idx;
      dy = lane_in.x >>> step_idx;
      if (lane_in.y > 0) begin
         lane_in_nxt.x   = lane_in.x + dx;
         lane_in_nxt.y   = lane_in.y - dy;
         lane_in_nxt.ang = lane_in.ang + aomd_pkg::atan_q16(step_idx);
      end else begin
         lane_in_nxt.x   = lane_in.x - dx;
         lane_in_nxt.y   = lane_in.y + dy;
         lane_in_nxt.ang = lane_in.ang - aomd_pkg::atan_q16(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      lane_ff <= lane_in_nxt;
   end

   assign vld_out  = vld_ff;
   assign lane_out = lane_ff;
endmodule

// ===== rtl/accel_orientation_motion_detector.sv =====
// Top level: sample conditioning, orientation flags and CORDIC heading chain
//  channel  dir  handshake    payload
//  req_ch   in   valid/ready  from_analog, sample_x/y/z
//  rsp_ch   out  valid/ready  norm_x/y/z, heading_deg, is_level, is_upright, shaking, flipped
//  csr_ch   in   valid/ready  index, data (always ready)
// One item at a time: accept, the start register, the CORDIC cell chain, the
// degree fixup into the heading register, then the result is held until taken;
// no new sample is accepted before then. Reset is synchronous; it clears the
// state and control registers to their defaults and the previous-sample state to zero.
// A stalled result holds the block in the done state.
`include "assert_macros.svh"

module accel_orientation_motion_detector (
   input  logic        clock,
   input  logic        reset,
   aomd_req_if.sink    req_ch,
   aomd_rsp_if.source  rsp_ch,
   aomd_csr_if.sink    csr_ch
);
   localparam int N = aomd_pkg::CordicSteps;

   aomd_pkg::state_type state_ff, state_in;

   logic        x_miss_ff, y_miss_ff, z_miss_ff;
   logic [16:0] shake_lim_ff;
   logic [14:0] flip_lim_ff, horiz_lim_ff, vert_lim_ff;
   logic signed [15:0] prev_x_ff, prev_y_ff, prev_z_ff;

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic        level_ff, upright_ff, shake_ff, flip_ff;
   logic        spec_ff;
   logic [8:0]  spec_deg_ff, hdg_ff;
   logic        start_ff;
   aomd_pkg::lane_type start_lane_ff;

   logic [N:0]         lane_vld;
   aomd_pkg::lane_type lane [0:N];

   logic req_acc, rsp_acc, chain_done;

   // ---------------- conditioning ----------------
   logic signed [23:0] ax, ay, az;
   logic signed [15:0] nx, ny, nz;
   logic [14:0]        mz;
   logic signed [17:0] sum;
   logic signed [16:0] fl;
   logic               spec;
   logic [8:0]         spec_deg;
   aomd_pkg::lane_type lane0;

   function automatic logic signed [23:0] axis_val(input logic an, input logic miss,
                                                   input logic signed [15:0] s);
      logic signed [23:0] v;
      if (!an)       v = 24'(s);
      else if (miss) v = 24'(aomd_pkg::OneG);
      else           v = (24'(s) - 24'sd512) <<< 6;
      return v;
   endfunction

   function automatic logic signed [15:0] clamp_g(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'(aomd_pkg::OneG))       r = aomd_pkg::OneG;
      else if (v < -24'(aomd_pkg::OneG)) r = -aomd_pkg::OneG;
      else                               r = v[15:0];
      return r;
   endfunction

   function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return (d < 0) ? 17'(-d) : 17'(d);
   endfunction

   always_comb begin
      ax = axis_val(req_ch.from_analog, x_miss_ff, req_ch.sample_x);
      ay = axis_val(req_ch.from_analog, y_miss_ff, req_ch.sample_y);
      az = axis_val(req_ch.from_analog, z_miss_ff, req_ch.sample_z);
      nx = clamp_g(ax);
      ny = clamp_g(ay);
      nz = clamp_g(az);
      mz = (nz < 0) ? 15'(-nz) : 15'(nz);
      sum = 18'(absdiff(nx, prev_x_ff)) + 18'(absdiff(ny, prev_y_ff))
          + 18'(absdiff(nz, prev_z_ff));
      fl = 17'(flip_lim_ff);

      // axes and diagonals are exact
      spec = 1'b1;
      priority if (ay == 0)  spec_deg = (ax < 0) ? 9'd180 : 9'd0;
      else if (ax == 0)      spec_deg = (ay > 0) ? 9'd90 : 9'd270;
      else if (ax == ay)     spec_deg = (ax > 0) ? 9'd45 : 9'd225;
      else if (ax == -ay)    spec_deg = (ax > 0) ? 9'd315 : 9'd135;
      else begin
         spec     = 1'b0;
         spec_deg = 9'd0;
      end

      // fold the left half plane onto the right
      if (ax < 0) begin
         lane0.x   = 36'(-ax) <<< 8;
         lane0.y   = 36'(-ay) <<< 8;
         lane0.ang = (ay > 0) ? (28'sd180 <<< aomd_pkg::DegQ)
                              : -(28'sd180 <<< aomd_pkg::DegQ);
      end else begin
         lane0.x   = 36'(ax) <<< 8;
         lane0.y   = 36'(ay) <<< 8;
         lane0.ang = '0;
      end
   end

   // ---------------- CORDIC chain ----------------
   assign lane_vld[0] = start_ff;
   assign lane[0]     = start_lane_ff;

   for (genvar k = 0; k < N; k++) begin : g_cell
      aomd_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_idx (aomd_pkg::StepIdxW'(k)),
         .vld_in   (lane_vld[k]),
         .lane_in  (lane[k]),
         .vld_out  (lane_vld[k+1]),
         .lane_out (lane[k+1])
      );
   end

   assign chain_done = lane_vld[N];

   logic signed [aomd_pkg::AngW-1:0] zp;
   logic signed [11:0] q;
   logic [8:0]         hdg;
   always_comb begin
      zp = (lane[N].ang < 0) ? lane[N].ang + (28'sd360 <<< aomd_pkg::DegQ) : lane[N].ang;
      q  = 12'(zp >>> aomd_pkg::DegQ);
      if (q >= 12'sd360) q = q - 12'sd360;
      if (q < 0)         q = '0;
      hdg = spec_ff ? spec_deg_ff : q[8:0];
   end

   // ---------------- control ----------------
   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aomd_pkg::S_IDLE: if (req_acc)    state_in = aomd_pkg::S_RUN;
         aomd_pkg::S_RUN:  if (chain_done) state_in = aomd_pkg::S_DONE;
         aomd_pkg::S_DONE: if (rsp_acc)    state_in = aomd_pkg::S_IDLE;
         default:                          state_in = aomd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == aomd_pkg::S_IDLE);
      rsp_ch.valid = (state_ff == aomd_pkg::S_DONE);
   end

   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.norm_x      = nx_ff;
   assign rsp_ch.norm_y      = ny_ff;
   assign rsp_ch.norm_z      = nz_ff;
   assign rsp_ch.heading_deg = hdg_ff;
   assign rsp_ch.is_level    = level_ff;
   assign rsp_ch.is_upright  = upright_ff;
   assign rsp_ch.shaking     = shake_ff;
   assign rsp_ch.flipped     = flip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aomd_pkg::S_IDLE;
         start_ff     <= 1'b0;
         x_miss_ff    <= 1'b0;
         y_miss_ff    <= 1'b0;
         z_miss_ff    <= 1'b0;
         shake_lim_ff <= aomd_pkg::ShakeLimitRst;
         flip_lim_ff  <= aomd_pkg::FlipLimitRst;
         horiz_lim_ff <= aomd_pkg::HorizLimitRst;
         vert_lim_ff  <= aomd_pkg::VertLimitRst;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_acc;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (aomd_pkg::csr_idx_type'(csr_ch.index))
               aomd_pkg::CSR_X_MISSING:   x_miss_ff    <= csr_ch.data[0];
               aomd_pkg::CSR_Y_MISSING:   y_miss_ff    <= csr_ch.data[0];
               aomd_pkg::CSR_Z_MISSING:   z_miss_ff    <= csr_ch.data[0];
               aomd_pkg::CSR_SHAKE_LIMIT: shake_lim_ff <= csr_ch.data;
               aomd_pkg::CSR_FLIP_LIMIT:  flip_lim_ff  <= csr_ch.data[14:0];
               aomd_pkg::CSR_HORIZ_LIMIT: horiz_lim_ff <= csr_ch.data[14:0];
               aomd_pkg::CSR_VERT_LIMIT:  vert_lim_ff  <= csr_ch.data[14:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            prev_x_ff <= nx;
            prev_y_ff <= ny;
            prev_z_ff <= nz;
         end
      end
      if (req_acc) begin
         nx_ff         <= nx;
         ny_ff         <= ny;
         nz_ff         <= nz;
         level_ff      <= (mz > horiz_lim_ff);
         upright_ff    <= (mz < vert_lim_ff);
         shake_ff      <= (sum > 18'(shake_lim_ff));
         flip_ff       <= ((17'(prev_z_ff) > fl) && (17'(nz) < -fl))
                       || ((17'(prev_z_ff) < -fl) && (17'(nz) > fl));
         spec_ff       <= spec;
         spec_deg_ff   <= spec_deg;
         start_lane_ff <= lane0;
      end
      if (chain_done) hdg_ff <= hdg;
   end

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_accept_starts_run, clock, reset, req_acc, state_ff == aomd_pkg::S_RUN)
   `ASSERT_IMPL(a_done_only_in_run, clock, reset, chain_done, state_ff == aomd_pkg::S_RUN)
   `ASSERT_NEVER(a_one_in_flight, clock, reset, $countones(lane_vld) > 1)
   `ASSERT_IMPL(a_idle_chain_empty, clock, reset, state_ff != aomd_pkg::S_RUN,
                lane_vld[N:1] == '0)
endmodule
